[rtl/rsi_pkg.sv]
// Types and constants shared by the ray/sphere intersection pipeline.
`default_nettype none
package rsi_pkg;

  localparam int DATA_W = 32;
  localparam int RAD_W  = 31;
  localparam int OC_W   = 33;
  localparam int A_W    = 64;
  localparam int H_W    = 65;
  localparam int HS_W   = 67;
  localparam int C_W    = 66;
  localparam int RR_W   = 62;
  localparam int D_W    = 132;
  localparam int S_W    = 66;
  localparam int SR_W   = 70;
  localparam int N_W    = 67;
  localparam int Q_W    = 31;
  localparam int CFG_W  = 16;

  localparam logic [CFG_W-1:0] MIN_DIST_RESET = 16'd66;
  localparam logic [Q_W-1:0]   DIST_MAX       = {Q_W{1'b1}};

  typedef struct packed {
    logic signed [DATA_W-1:0] center_x;
    logic signed [DATA_W-1:0] center_y;
    logic signed [DATA_W-1:0] center_z;
    logic        [RAD_W-1:0]  sphere_radius;
    logic signed [DATA_W-1:0] ray_origin_x;
    logic signed [DATA_W-1:0] ray_origin_y;
    logic signed [DATA_W-1:0] ray_origin_z;
    logic signed [DATA_W-1:0] ray_dir_x;
    logic signed [DATA_W-1:0] ray_dir_y;
    logic signed [DATA_W-1:0] ray_dir_z;
  } rsi_in_t;

  typedef struct packed {
    logic           hit;
    logic [Q_W-1:0] hit_distance;
  } rsi_out_t;

  typedef struct packed {
    logic [A_W-1:0] a;
    logic [H_W-1:0] hmag;
    logic           h_neg;
    logic [C_W-1:0] cmag;
    logic           c_neg;
    logic           miss;
  } coef_t;

  typedef struct packed {
    logic [D_W-1:0] d;
    logic [A_W-1:0] a;
    logic [H_W-1:0] hmag;
    logic           h_neg;
    logic           miss;
  } disc_t;

  typedef struct packed {
    logic [S_W-1:0] s;
    logic [A_W-1:0] a;
    logic [H_W-1:0] hmag;
    logic           h_neg;
    logic           miss;
  } sq_t;

  typedef struct packed {
    logic [Q_W-1:0] t1;
    logic [Q_W-1:0] t2;
    logic           ok1;
    logic           ok2;
    logic           miss;
  } dv_t;

endpackage
`default_nettype wire

[rtl/rsi_coef.sv]
// Quadratic coefficient stages: offsets, products, sums, magnitudes.
`default_nettype none
module rsi_coef import rsi_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         ready_o,
  input  wire rsi_in_t data_i,
  output logic         valid_o,
  input  wire logic    ready_i,
  output coef_t        data_o
);

  localparam int NS = 4;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic [OC_W-1:0]   om_d [3];
  logic [DATA_W-1:0] dm_d [3];
  logic              sx_d [3];
  logic [OC_W-1:0]   om_q [3];
  logic [DATA_W-1:0] dm_q [3];
  logic              sx_q [3];
  logic [RAD_W-1:0]  r_q;

  logic [H_W-1:0]    pod_q [3];
  logic [A_W-1:0]    pdd_q [3];
  logic [C_W-1:0]    poo_q [3];
  logic              sx1_q [3];
  logic [RR_W-1:0]   rr1_q;

  logic [A_W-1:0]    a2_q;
  logic [HS_W-1:0]   h2_q;
  logic [C_W-1:0]    cp2_q;
  logic [RR_W-1:0]   rr2_q;
  logic [HS_W-1:0]   h_d;

  coef_t             out_q;
  logic [HS_W-1:0]   hab;

  assign en[NS] = ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    logic signed [DATA_W-1:0] o [3];
    logic signed [DATA_W-1:0] c [3];
    logic signed [DATA_W-1:0] d [3];
    logic signed [OC_W-1:0]   oc;
    o[0] = data_i.ray_origin_x; o[1] = data_i.ray_origin_y; o[2] = data_i.ray_origin_z;
    c[0] = data_i.center_x;     c[1] = data_i.center_y;     c[2] = data_i.center_z;
    d[0] = data_i.ray_dir_x;    d[1] = data_i.ray_dir_y;    d[2] = data_i.ray_dir_z;
    for (int i = 0; i < 3; i++) begin
      oc       = OC_W'(o[i]) - OC_W'(c[i]);
      om_d[i]  = oc[OC_W-1] ? OC_W'(-oc) : OC_W'(oc);
      dm_d[i]  = d[i][DATA_W-1] ? DATA_W'(-d[i]) : DATA_W'(d[i]);
      sx_d[i]  = oc[OC_W-1] ^ d[i][DATA_W-1];
    end
  end

  always_comb begin
    h_d = '0;
    for (int i = 0; i < 3; i++) begin
      h_d = sx1_q[i] ? h_d - HS_W'(pod_q[i]) : h_d + HS_W'(pod_q[i]);
    end
  end

  assign hab = h2_q[HS_W-1] ? -h2_q : h2_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      om_q <= om_d;
      dm_q <= dm_d;
      sx_q <= sx_d;
      r_q  <= data_i.sphere_radius;
    end
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        pod_q[i] <= H_W'(om_q[i]) * H_W'(dm_q[i]);
        pdd_q[i] <= A_W'(dm_q[i]) * A_W'(dm_q[i]);
        poo_q[i] <= C_W'(om_q[i]) * C_W'(om_q[i]);
      end
      sx1_q <= sx_q;
      rr1_q <= RR_W'(r_q) * RR_W'(r_q);
    end
    if (en[2]) begin
      a2_q  <= pdd_q[0] + pdd_q[1] + pdd_q[2];
      h2_q  <= h_d;
      cp2_q <= poo_q[0] + poo_q[1] + poo_q[2];
      rr2_q <= rr1_q;
    end
    if (en[3]) begin
      out_q.a     <= a2_q;
      out_q.hmag  <= hab[H_W-1:0];
      out_q.h_neg <= h2_q[HS_W-1];
      out_q.c_neg <= C_W'(rr2_q) > cp2_q;
      out_q.cmag  <= (C_W'(rr2_q) > cp2_q) ? C_W'(rr2_q) - cp2_q : cp2_q - C_W'(rr2_q);
      out_q.miss  <= a2_q == '0;
    end
  end

endmodule
`default_nettype wire

[rtl/rsi_disc.sv]
// Discriminant stages: split products, partial sums, sign test.
`default_nettype none
module rsi_disc import rsi_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire coef_t data_i,
  output logic       valid_o,
  input  wire logic  ready_i,
  output disc_t      data_o
);

  localparam int NS = 3;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic [65:0] hh_q;
  logic [64:0] hl2_q;
  logic [63:0] ll_q;
  logic [65:0] ahch_q;
  logic [63:0] ahcl_q;
  logic [65:0] alch_q;
  logic [63:0] alcl_q;
  coef_t       c0_q;

  logic [D_W-1:0] hsq_q;
  logic [D_W-1:0] ac_q;
  coef_t          c1_q;

  disc_t out_q;

  assign en[NS] = ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hh_q   <= 66'(data_i.hmag[64:32]) * 66'(data_i.hmag[64:32]);
      hl2_q  <= 65'(data_i.hmag[64:32]) * 65'(data_i.hmag[31:0]);
      ll_q   <= 64'(data_i.hmag[31:0]) * 64'(data_i.hmag[31:0]);
      ahch_q <= 66'(data_i.a[63:32]) * 66'(data_i.cmag[65:32]);
      ahcl_q <= 64'(data_i.a[63:32]) * 64'(data_i.cmag[31:0]);
      alch_q <= 66'(data_i.a[31:0]) * 66'(data_i.cmag[65:32]);
      alcl_q <= 64'(data_i.a[31:0]) * 64'(data_i.cmag[31:0]);
      c0_q   <= data_i;
    end
    if (en[1]) begin
      hsq_q <= (D_W'(hh_q) << 64) + (D_W'(hl2_q) << 33) + D_W'(ll_q);
      ac_q  <= (D_W'(ahch_q) << 64) + (D_W'(ahcl_q) << 32) + (D_W'(alch_q) << 32)
               + D_W'(alcl_q);
      c1_q  <= c0_q;
    end
    if (en[2]) begin
      out_q.d     <= c1_q.c_neg ? hsq_q + ac_q : hsq_q - ac_q;
      out_q.a     <= c1_q.a;
      out_q.hmag  <= c1_q.hmag;
      out_q.h_neg <= c1_q.h_neg;
      out_q.miss  <= c1_q.miss || (!c1_q.c_neg && (hsq_q < ac_q));
    end
  end

endmodule
`default_nettype wire

[rtl/rsi_sqrt.sv]
// Integer square root, one result bit per pipeline stage.
`default_nettype none
module rsi_sqrt import rsi_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire disc_t data_i,
  output logic       valid_o,
  input  wire logic  ready_i,
  output sq_t        data_o
);

  localparam int NS = S_W;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic [S_W-1:0]  root_q [NS];
  logic [SR_W-1:0] rem_q  [NS];
  disc_t           side_q [NS];

  assign en[NS] = ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  assign data_o.s     = root_q[NS-1];
  assign data_o.a     = side_q[NS-1].a;
  assign data_o.hmag  = side_q[NS-1].hmag;
  assign data_o.h_neg = side_q[NS-1].h_neg;
  assign data_o.miss  = side_q[NS-1].miss;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [S_W-1:0]  pr;
    logic [SR_W-1:0] pm;
    disc_t           ps;
    logic [SR_W-1:0] rem_sh;
    logic [SR_W-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign pr = '0;
      assign pm = '0;
      assign ps = data_i;
    end else begin : g_next
      assign pr = root_q[k-1];
      assign pm = rem_q[k-1];
      assign ps = side_q[k-1];
    end

    assign rem_sh = {pm[SR_W-3:0], ps.d[D_W-1-2*k -: 2]};
    assign trial  = {{(SR_W-S_W-2){1'b0}}, pr, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        root_q[k] <= {pr[S_W-2:0], ge};
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        side_q[k] <= ps;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/rsi_div.sv]
// Root numerators and two saturating restoring dividers, one bit per stage.
`default_nettype none
module rsi_div import rsi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire sq_t  data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output dv_t       data_o
);

  localparam int NS   = Q_W + 2;
  localparam int NUMW = N_W + FRAC_BITS;
  localparam int RDW  = (NUMW > A_W + Q_W) ? NUMW : A_W + Q_W;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic [RDW-1:0] r_q   [NS][2];
  logic [Q_W-1:0] q_q   [NS][2];
  logic           sat_q [NS][2];
  logic           ok_q  [NS][2];
  logic [A_W-1:0] a_q   [NS];
  logic           miss_q[NS];

  logic [N_W-1:0] n1_d, n2_d;
  logic           ok1_d, ok2_d;
  logic [S_W-1:0] s_w;
  logic [N_W-1:0] hm_w;

  assign en[NS] = ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  assign data_o.t1   = sat_q[NS-1][0] ? DIST_MAX : q_q[NS-1][0];
  assign data_o.t2   = sat_q[NS-1][1] ? DIST_MAX : q_q[NS-1][1];
  assign data_o.ok1  = ok_q[NS-1][0];
  assign data_o.ok2  = ok_q[NS-1][1];
  assign data_o.miss = miss_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
        end
      end
    end
  end

  assign s_w  = data_i.s;
  assign hm_w = N_W'(data_i.hmag);

  always_comb begin
    if (data_i.h_neg) begin
      ok1_d = hm_w >= N_W'(s_w);
      n1_d  = hm_w - N_W'(s_w);
      ok2_d = 1'b1;
      n2_d  = hm_w + N_W'(s_w);
    end else begin
      ok1_d = hm_w == N_W'(s_w);
      n1_d  = '0;
      ok2_d = N_W'(s_w) >= hm_w;
      n2_d  = N_W'(s_w) - hm_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      r_q[0][0]   <= RDW'(n1_d);
      r_q[0][1]   <= RDW'(n2_d);
      ok_q[0][0]  <= ok1_d;
      ok_q[0][1]  <= ok2_d;
      q_q[0][0]   <= '0;
      q_q[0][1]   <= '0;
      sat_q[0][0] <= 1'b0;
      sat_q[0][1] <= 1'b0;
      a_q[0]      <= data_i.a;
      miss_q[0]   <= data_i.miss;
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RDW-1:0] num;
      logic [RDW-1:0] lim;
      logic           ge;

      if (j == 1) begin : g_sat
        assign num = r_q[0][l] << FRAC_BITS;
        assign lim = RDW'(a_q[0]) << Q_W;
        assign ge  = num >= lim;
        always_ff @(posedge clk_i) begin
          if (en[j]) begin
            r_q[j][l]   <= num;
            q_q[j][l]   <= '0;
            sat_q[j][l] <= ge;
            ok_q[j][l]  <= ok_q[j-1][l];
          end
        end
      end else begin : g_bit
        assign num = r_q[j-1][l];
        assign lim = RDW'(a_q[j-1]) << (NS - 1 - j);
        assign ge  = num >= lim;
        always_ff @(posedge clk_i) begin
          if (en[j]) begin
            r_q[j][l]   <= ge ? num - lim : num;
            q_q[j][l]   <= {q_q[j-1][l][Q_W-2:0], ge};
            sat_q[j][l] <= sat_q[j-1][l];
            ok_q[j][l]  <= ok_q[j-1][l];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        a_q[j]    <= a_q[j-1];
        miss_q[j] <= miss_q[j-1];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/ray_sphere_intersect_top.sv]
// Top level of the ray/sphere intersection pipeline.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+---------------------------
//  input   | in_valid_i  | in_ready_o  | in_data_i  (rsi_in_t)
//  result  | out_valid_o | out_ready_i | out_data_o (rsi_out_t)
//  config  | cfg_valid_i | cfg_ready_o | cfg_data_i (min_distance)
//
//  One transfer per cycle in, one per cycle out while out_ready_i is held high;
//  stages: 4 coefficient, 3 discriminant, 66 square-root, 33 divider, 1 select.
//  The square root is the longest section, one result bit per stage.
//  Reset clears every stage valid and loads min_distance with 66.
//  Each stage advances when empty or when the stage after it advances,
//  so a stalled result lets the stages behind it fill up.
`default_nettype none
module ray_sphere_intersect_top import rsi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rsi_in_t          in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rsi_out_t              out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  logic [CFG_W-1:0] md_q;

  logic  cf_valid, cf_ready;
  coef_t cf_data;
  logic  ds_valid, ds_ready;
  disc_t ds_data;
  logic  sq_valid, sq_ready;
  sq_t   sq_data;
  logic  dv_valid, dv_ready;
  dv_t   dv_data;

  logic     out_valid_q;
  rsi_out_t out_q;
  rsi_out_t out_d;
  logic     out_en;
  logic     take1, take2;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q <= MIN_DIST_RESET;
    end else if (cfg_valid_i) begin
      md_q <= cfg_data_i;
    end
  end

  rsi_coef u_coef (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o), .data_i(in_data_i),
    .valid_o(cf_valid), .ready_i(cf_ready), .data_o(cf_data)
  );

  rsi_disc u_disc (
    .clk_i, .rst_ni,
    .valid_i(cf_valid), .ready_o(cf_ready), .data_i(cf_data),
    .valid_o(ds_valid), .ready_i(ds_ready), .data_o(ds_data)
  );

  rsi_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .valid_i(ds_valid), .ready_o(ds_ready), .data_i(ds_data),
    .valid_o(sq_valid), .ready_i(sq_ready), .data_o(sq_data)
  );

  rsi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni,
    .valid_i(sq_valid), .ready_o(sq_ready), .data_i(sq_data),
    .valid_o(dv_valid), .ready_i(dv_ready), .data_o(dv_data)
  );

  assign out_en   = !out_valid_q || out_ready_i;
  assign dv_ready = out_en;

  assign take1 = !dv_data.miss && dv_data.ok1 && (dv_data.t1 > Q_W'(md_q));
  assign take2 = !dv_data.miss && dv_data.ok2 && (dv_data.t2 > Q_W'(md_q));

  always_comb begin
    out_d = '0;
    if (take1) begin
      out_d.hit          = 1'b1;
      out_d.hit_distance = dv_data.t1;
    end else if (take2) begin
      out_d.hit          = 1'b1;
      out_d.hit_distance = dv_data.t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.hit_distance == '0)
    else $error("miss with nonzero distance");

  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.hit_distance != '0)
    else $error("hit with zero distance");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input held off without a blocked result");

endmodule
`default_nettype wire
